### rtl/pci_config_space_enumerator_defines.svh
// Assertion macros shared by the checker of the configuration space enumerator.
`ifndef PCI_CONFIG_SPACE_ENUMERATOR_DEFINES_SVH
`define PCI_CONFIG_SPACE_ENUMERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCSE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcse assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PCSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcse assertion failed");

`endif

### rtl/pcse_pkg.sv
// Shared types and constants of the configuration space enumerator.
package pcse_pkg;

    // Action codes of an input item.
    localparam logic [1:0] A_START = 2'd0;
    localparam logic [1:0] A_DATA  = 2'd1;
    localparam logic [1:0] A_FIND  = 2'd2;
    localparam logic [1:0] A_BAR   = 2'd3;

    // Result kinds.
    localparam logic [2:0] K_REQ     = 3'd0;
    localparam logic [2:0] K_DONE    = 3'd1;
    localparam logic [2:0] K_FULL    = 3'd2;
    localparam logic [2:0] K_MATCH   = 3'd3;
    localparam logic [2:0] K_NOMATCH = 3'd4;
    localparam logic [2:0] K_BAR     = 3'd5;
    localparam logic [2:0] K_REJECT  = 3'd6;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_REJECT,
        OP_NOMATCH,
        OP_TAKE,
        OP_CLEAR,
        OP_BAR_REQ,
        OP_BAR_OUT,
        OP_FIND_INIT,
        OP_FIND_MATCH,
        OP_FIND_NEXT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic ready;
        logic need_clear;
        logic find_ok;
        logic bar_ok;
        logic clr_last;
        logic fmatch;
        logic flast;
    } status_t;

    // One table entry.
    typedef struct packed {
        logic [15:0] vendor;
        logic [15:0] device;
        logic [7:0]  bus;
        logic [4:0]  slot;
        logic [2:0]  func;
        logic [7:0]  cls;
        logic [7:0]  sub;
        logic [7:0]  pif;
        logic [7:0]  hdr;
        logic [7:0]  line;
        logic [7:0]  pin;
    } entry_t;

endpackage

### rtl/pci_config_space_enumerator.sv
// Top level of the PCI configuration space enumerator.
//
// Usage: an item is taken when start is high and busy is low; action picks
// start, configuration read data, find by class or BAR read. Every item gives
// exactly one result, shown for one cycle with strobe high; the receiver
// cannot stall, so it must take each result in the cycle it appears.
// A start or a read-data item answers with the next read request (kind 0),
// an end of walk or a full table; the host performs the read and returns
// the word with a read-data item. Most results are registered and appear in
// the cycle after the item is taken. A function found present first clears
// its six BAR slots, one memory write a cycle. A BAR read shows the value
// of a registered memory read. A find query scans the filled entries, a
// memory read then a compare each, up to the first match. Busy is high
// while such an item is in progress. Reset clears the walk, the entry count
// and the flags; the tables need no clearing, as only filled entries are read.
module pci_config_space_enumerator #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] read_data,
    input  logic [7:0]  base_class,
    input  logic [7:0]  subclass_code,
    input  logic [7:0]  prog_interface,
    input  logic [7:0]  entry_select,
    input  logic [2:0]  bar_select,
    output logic        strobe,
    output logic [2:0]  kind,
    output logic [31:0] config_address,
    output logic [7:0]  entry_index,
    output logic [15:0] vendor_id,
    output logic [15:0] device_id,
    output logic [7:0]  entry_bus,
    output logic [4:0]  entry_device,
    output logic [2:0]  entry_function,
    output logic [7:0]  header_kind,
    output logic [7:0]  irq_line,
    output logic [7:0]  irq_pin,
    output logic [63:0] bar_value
);
    import pcse_pkg::*;

    cmd_t    cmd;
    status_t status;

    pcse_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    pcse_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .read_data       (read_data),
        .base_class      (base_class),
        .subclass_code   (subclass_code),
        .prog_interface  (prog_interface),
        .entry_select    (entry_select),
        .bar_select      (bar_select),
        .strobe          (strobe),
        .kind            (kind),
        .config_address  (config_address),
        .entry_index     (entry_index),
        .vendor_id       (vendor_id),
        .device_id       (device_id),
        .entry_bus       (entry_bus),
        .entry_device    (entry_device),
        .entry_function  (entry_function),
        .header_kind     (header_kind),
        .irq_line        (irq_line),
        .irq_pin         (irq_pin),
        .bar_value       (bar_value)
    );

endmodule

### rtl/pcse_datapath.sv
// Datapath: walk registers, entry table, BAR table and result registers.
module pcse_datapath #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pcse_pkg::cmd_t      cmd,
    output pcse_pkg::status_t   status,
    input  logic [31:0]         read_data,
    input  logic [7:0]          base_class,
    input  logic [7:0]          subclass_code,
    input  logic [7:0]          prog_interface,
    input  logic [7:0]          entry_select,
    input  logic [2:0]          bar_select,
    output logic                strobe,
    output logic [2:0]          kind,
    output logic [31:0]         config_address,
    output logic [7:0]          entry_index,
    output logic [15:0]         vendor_id,
    output logic [15:0]         device_id,
    output logic [7:0]          entry_bus,
    output logic [4:0]          entry_device,
    output logic [2:0]          entry_function,
    output logic [7:0]          header_kind,
    output logic [7:0]          irq_line,
    output logic [7:0]          irq_pin,
    output logic [63:0]         bar_value
);
    import pcse_pkg::*;

    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int BD = MAX_ENTRIES * 6;
    localparam int AW = $clog2(BD);

    localparam logic [2:0] PH_ID     = 3'd0;
    localparam logic [2:0] PH_CLASS  = 3'd1;
    localparam logic [2:0] PH_HDR    = 3'd2;
    localparam logic [2:0] PH_INT    = 3'd3;
    localparam logic [2:0] PH_BAR_LO = 3'd4;
    localparam logic [2:0] PH_BAR_HI = 3'd5;

    // Walk state.
    logic          active_reg, active_next;
    logic          ready_reg, ready_next;
    logic [15:0]   pos_reg, pos_next;
    logic [2:0]    phase_reg, phase_next;
    logic [2:0]    slot_reg, slot_next;
    logic [CW-1:0] count_reg, count_next;
    logic [2:0]    clr_reg, clr_next;
    logic [EW-1:0] idx_reg, idx_next;
    entry_t        rec_reg, rec_next;
    logic [31:0]   low_reg, low_next;
    logic [7:0]    qcc_reg, qcc_next, qsc_reg, qsc_next, qpi_reg, qpi_next;

    // Result registers.
    logic          strobe_reg, strobe_next;
    logic [2:0]    kind_reg, kind_next;
    logic [31:0]   addr_reg, addr_next;
    logic [7:0]    eidx_reg, eidx_next;
    entry_t        orec_reg, orec_next;
    logic [63:0]   bar_reg, bar_next;

    // Memories.
    entry_t        fld_mem [MAX_ENTRIES];
    logic [63:0]   bar_mem [BD];
    entry_t        fld_rd_reg;
    logic [63:0]   bar_rd_reg;
    logic          fld_we, bar_we;
    entry_t        fld_wd;
    logic [63:0]   bar_wd;
    logic [AW-1:0] bar_wa, bar_ra;
    logic [EW-1:0] cur;
    logic [CW-1:0] cur_w;
    logic [11:0]   wa_full, ra_full;

    logic          req_en, do_adv, do_nbar;
    logic [7:0]    req_off;
    logic [2:0]    nbar_slot, s_slot;

    assign cur_w   = count_reg - CW'(1);
    assign cur     = cur_w[EW-1:0];
    assign ra_full = (12'(entry_select[EW-1:0]) << 2) + (12'(entry_select[EW-1:0]) << 1)
                     + 12'(bar_select);
    assign bar_ra  = ra_full[AW-1:0];

    // Status toward the controller.
    always_comb
    begin
        status.active     = active_reg;
        status.ready      = ready_reg;
        status.need_clear = (phase_reg == PH_ID) && (read_data[15:0] != 16'hFFFF)
                            && (count_reg < CW'(MAX_ENTRIES));
        status.find_ok    = ready_reg && (count_reg != '0);
        status.bar_ok     = (9'(entry_select) < 9'(count_reg)) && (bar_select < 3'd6);
        status.clr_last   = (clr_reg == 3'd5);
        status.fmatch     = (fld_rd_reg.cls == qcc_reg) && (fld_rd_reg.sub == qsc_reg)
                            && ((qpi_reg == 8'hFF) || (fld_rd_reg.pif == qpi_reg));
        status.flast      = (9'(idx_reg) + 9'd1) >= 9'(count_reg);
    end

    // Next-state logic of the walk and the result registers.
    always_comb
    begin
        active_next = active_reg;
        ready_next  = ready_reg;
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        slot_next   = slot_reg;
        count_next  = count_reg;
        clr_next    = clr_reg;
        idx_next    = idx_reg;
        rec_next    = rec_reg;
        low_next    = low_reg;
        qcc_next    = qcc_reg;
        qsc_next    = qsc_reg;
        qpi_next    = qpi_reg;
        strobe_next = 1'b0;
        kind_next   = K_REQ;
        addr_next   = '0;
        eidx_next   = '0;
        orec_next   = '0;
        bar_next    = '0;
        fld_we      = 1'b0;
        fld_wd      = rec_reg;
        bar_we      = 1'b0;
        wa_full     = (12'(cur) << 2) + (12'(cur) << 1) + 12'(slot_reg);
        bar_wd      = '0;
        req_en      = 1'b0;
        req_off     = '0;
        do_adv      = 1'b0;
        do_nbar     = 1'b0;
        nbar_slot   = '0;
        s_slot      = slot_reg;

        case (cmd.op)
            OP_START:
            begin
                count_next  = '0;
                pos_next    = '0;
                phase_next  = PH_ID;
                slot_next   = '0;
                active_next = 1'b1;
                req_en      = 1'b1;
            end
            OP_REJECT:
            begin
                strobe_next = 1'b1;
                kind_next   = K_REJECT;
            end
            OP_NOMATCH:
            begin
                strobe_next = 1'b1;
                kind_next   = K_NOMATCH;
            end
            OP_TAKE:
            begin
                case (phase_reg)
                    PH_ID:
                    begin
                        if (read_data[15:0] == 16'hFFFF)
                        begin
                            do_adv = 1'b1;
                        end
                        else if (count_reg >= CW'(MAX_ENTRIES))
                        begin
                            active_next = 1'b0;
                            ready_next  = 1'b0;
                            strobe_next = 1'b1;
                            kind_next   = K_FULL;
                        end
                        else
                        begin
                            rec_next.vendor = read_data[15:0];
                            rec_next.device = read_data[31:16];
                            rec_next.bus    = pos_reg[15:8];
                            rec_next.slot   = pos_reg[7:3];
                            rec_next.func   = pos_reg[2:0];
                            count_next      = count_reg + CW'(1);
                            phase_next      = PH_CLASS;
                            clr_next        = '0;
                        end
                    end
                    PH_CLASS:
                    begin
                        rec_next.pif = read_data[15:8];
                        rec_next.sub = read_data[23:16];
                        rec_next.cls = read_data[31:24];
                        phase_next   = PH_HDR;
                        req_en       = 1'b1;
                        req_off      = 8'h0C;
                    end
                    PH_HDR:
                    begin
                        rec_next.hdr = read_data[23:16];
                        phase_next   = PH_INT;
                        req_en       = 1'b1;
                        req_off      = 8'h3C;
                    end
                    PH_INT:
                    begin
                        rec_next.line = read_data[7:0];
                        rec_next.pin  = read_data[15:8];
                        fld_we        = 1'b1;
                        fld_wd        = rec_next;
                        if ((rec_reg.hdr & 8'h7F) != 8'h00)
                        begin
                            do_adv = 1'b1;
                        end
                        else
                        begin
                            do_nbar   = 1'b1;
                            nbar_slot = 3'd0;
                        end
                    end
                    PH_BAR_LO:
                    begin
                        // Zero words leave the slot cleared.
                        if (read_data == 32'h0)
                        begin
                            do_nbar   = 1'b1;
                            nbar_slot = s_slot + 3'd1;
                        end
                        else if (read_data[0])
                        begin
                            bar_we    = 1'b1;
                            bar_wd    = {32'h0, read_data & ~32'h3};
                            do_nbar   = 1'b1;
                            nbar_slot = s_slot + 3'd1;
                        end
                        else
                        begin
                            bar_we = 1'b1;
                            bar_wd = {32'h0, read_data & ~32'hF};
                            if ((read_data[2:1] == 2'd2) && (s_slot < 3'd5))
                            begin
                                low_next   = read_data & ~32'hF;
                                phase_next = PH_BAR_HI;
                                req_en     = 1'b1;
                                req_off    = {3'b000, s_slot + 3'd1, 2'b00} + 8'h10;
                            end
                            else
                            begin
                                do_nbar   = 1'b1;
                                nbar_slot = s_slot + 3'd1;
                            end
                        end
                    end
                    default:
                    begin
                        // High word of a 64-bit memory BAR.
                        bar_we    = 1'b1;
                        bar_wd    = {read_data, low_reg};
                        do_nbar   = 1'b1;
                        nbar_slot = s_slot + 3'd2;
                    end
                endcase
            end
            OP_CLEAR:
            begin
                bar_we   = 1'b1;
                wa_full  = (12'(cur) << 2) + (12'(cur) << 1) + 12'(clr_reg);
                clr_next = clr_reg + 3'd1;
                if (clr_reg == 3'd5)
                begin
                    req_en  = 1'b1;
                    req_off = 8'h08;
                end
            end
            OP_BAR_OUT:
            begin
                strobe_next = 1'b1;
                kind_next   = K_BAR;
                bar_next    = bar_rd_reg;
            end
            OP_FIND_INIT:
            begin
                idx_next = '0;
                qcc_next = base_class;
                qsc_next = subclass_code;
                qpi_next = prog_interface;
            end
            OP_FIND_MATCH:
            begin
                strobe_next = 1'b1;
                kind_next   = K_MATCH;
                eidx_next   = 8'(idx_reg);
                orec_next   = fld_rd_reg;
            end
            OP_FIND_NEXT:
            begin
                idx_next = idx_reg + EW'(1);
            end
            default:
            begin
            end
        endcase

        // Move to the next BAR slot or leave the function.
        if (do_nbar)
        begin
            slot_next = nbar_slot;
            if (nbar_slot >= 3'd6)
            begin
                do_adv = 1'b1;
            end
            else
            begin
                phase_next = PH_BAR_LO;
                req_en     = 1'b1;
                req_off    = {3'b000, nbar_slot, 2'b00} + 8'h10;
            end
        end

        // Step to the next bus, device and function, or end the walk after the last.
        if (do_adv)
        begin
            if (pos_reg == 16'hFFFF)
            begin
                active_next = 1'b0;
                ready_next  = 1'b1;
                strobe_next = 1'b1;
                kind_next   = K_DONE;
            end
            else
            begin
                pos_next   = pos_reg + 16'd1;
                phase_next = PH_ID;
                req_en     = 1'b1;
                req_off    = 8'h00;
            end
        end

        // Configuration read request.
        if (req_en)
        begin
            strobe_next = 1'b1;
            kind_next   = K_REQ;
            addr_next   = 32'h8000_0000 | {8'h00, pos_next, 8'h00} | {24'h0, req_off & 8'hFC};
        end
    end

    assign bar_wa = wa_full[AW-1:0];

    // Control and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ready_reg  <= 1'b0;
            pos_reg    <= '0;
            phase_reg  <= '0;
            slot_reg   <= '0;
            count_reg  <= '0;
            clr_reg    <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            ready_reg  <= ready_next;
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            slot_reg   <= slot_next;
            count_reg  <= count_next;
            clr_reg    <= clr_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rec_reg  <= rec_next;
        low_reg  <= low_next;
        qcc_reg  <= qcc_next;
        qsc_reg  <= qsc_next;
        qpi_reg  <= qpi_next;
        kind_reg <= kind_next;
        addr_reg <= addr_next;
        eidx_reg <= eidx_next;
        orec_reg <= orec_next;
        bar_reg  <= bar_next;
    end

    // Entry table memory.
    always_ff @(posedge clk)
    begin
        if (fld_we)
        begin
            fld_mem[cur] <= fld_wd;
        end
        fld_rd_reg <= fld_mem[idx_reg];
    end

    // BAR table memory.
    always_ff @(posedge clk)
    begin
        if (bar_we)
        begin
            bar_mem[bar_wa] <= bar_wd;
        end
        bar_rd_reg <= bar_mem[bar_ra];
    end

    assign strobe          = strobe_reg;
    assign kind            = kind_reg;
    assign config_address  = addr_reg;
    assign entry_index     = eidx_reg;
    assign vendor_id       = orec_reg.vendor;
    assign device_id       = orec_reg.device;
    assign entry_bus       = orec_reg.bus;
    assign entry_device    = orec_reg.slot;
    assign entry_function  = orec_reg.func;
    assign header_kind     = orec_reg.hdr;
    assign irq_line        = orec_reg.line;
    assign irq_pin         = orec_reg.pin;
    assign bar_value       = bar_reg;

endmodule

### rtl/pcse_ctrl.sv
// Controller state machine that sequences the datapath.
module pcse_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         action,
    input  pcse_pkg::status_t  status,
    output pcse_pkg::cmd_t     cmd,
    output logic               busy
);
    import pcse_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLEAR = 5'b00010,
        S_BAR   = 5'b00100,
        S_FRD   = 5'b01000,
        S_FCMP  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Decode accepted items and step through multi-cycle operations.
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        A_START:
                        begin
                            cmd.op = (status.active || status.ready) ? OP_REJECT : OP_START;
                        end
                        A_DATA:
                        begin
                            if (!status.active)
                            begin
                                cmd.op = OP_REJECT;
                            end
                            else
                            begin
                                cmd.op = OP_TAKE;
                                if (status.need_clear)
                                begin
                                    state_next = S_CLEAR;
                                end
                            end
                        end
                        A_FIND:
                        begin
                            if (status.find_ok)
                            begin
                                cmd.op     = OP_FIND_INIT;
                                state_next = S_FRD;
                            end
                            else
                            begin
                                cmd.op = OP_NOMATCH;
                            end
                        end
                        default:
                        begin
                            if (status.bar_ok)
                            begin
                                cmd.op     = OP_BAR_REQ;
                                state_next = S_BAR;
                            end
                            else
                            begin
                                cmd.op = OP_NOMATCH;
                            end
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_BAR:
            begin
                cmd.op     = OP_BAR_OUT;
                state_next = S_IDLE;
            end
            S_FRD:
            begin
                state_next = S_FCMP;
            end
            S_FCMP:
            begin
                if (status.fmatch)
                begin
                    cmd.op     = OP_FIND_MATCH;
                    state_next = S_IDLE;
                end
                else if (status.flast)
                begin
                    cmd.op     = OP_NOMATCH;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_FIND_NEXT;
                    state_next = S_FRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

### rtl/pcse_checker.sv
// Port-level checker of the enumerator and its bind statement.
`include "pci_config_space_enumerator_defines.svh"

module pcse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        strobe,
    input logic [2:0]  kind,
    input logic [31:0] config_address,
    input logic [63:0] bar_value
);
    import pcse_pkg::*;

    // An accepted item gives a result next cycle or keeps the block busy.
    `PCSE_ASSERT_NEXT(a_item_progress, clk, rst_n, start && !busy, strobe || busy)

    // A read request carries the enable bit and a dword-aligned offset.
    `PCSE_ASSERT_SAME(a_req_form, clk, rst_n, strobe && (kind == K_REQ), config_address[31] && (config_address[1:0] == 2'b00))

    // Only read requests carry an address.
    `PCSE_ASSERT_SAME(a_addr_zero, clk, rst_n, strobe && (kind != K_REQ), config_address == 32'h0)

    // Only BAR results carry a BAR value.
    `PCSE_ASSERT_SAME(a_bar_zero, clk, rst_n, strobe && (kind != K_BAR), bar_value == 64'h0)

endmodule

bind pci_config_space_enumerator pcse_checker u_pcse_checker (.*);
